/* hdl/rmfbw_pkg.sv */
package rmfbw_pkg;

  // Panel geometry
  localparam int unsigned PANEL_COLS = 240;
  localparam int unsigned PANEL_ROWS = 416;

  localparam int unsigned ROW_BYTES   = PANEL_COLS / 8;
  localparam int unsigned STORE_BYTES = (PANEL_COLS * PANEL_ROWS) / 8;

  localparam int unsigned ADDR_W  = $clog2(STORE_BYTES);
  localparam int unsigned CLR_W   = $clog2(STORE_BYTES + 1);
  localparam int unsigned COL_W   = $clog2(PANEL_COLS + 1);
  localparam int unsigned ROW_W   = $clog2(PANEL_ROWS + 1);
  localparam int unsigned IDX_MAX = (PANEL_ROWS - 1) * ROW_BYTES + (PANEL_COLS - 1) / 8;
  localparam int unsigned IDX_W   = $clog2(IDX_MAX + 2);

  // Pixel threshold and byte constants
  localparam logic [15:0] WHITE_THRESHOLD = 16'h7fff;
  localparam logic [7:0]  BYTE_WHITE      = 8'hff;
  localparam logic [7:0]  MASK_MSB        = 8'h80;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOGICAL_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOGICAL_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_H       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_V       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_AXES      = 3'd4;

  localparam logic [9:0] WIDTH_RESET  = 10'd416;
  localparam logic [9:0] HEIGHT_RESET = 10'd240;

  typedef struct packed {
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [15:0] pixel_rgb565;
    logic        area_end;
  } pixel_req_t;

  typedef struct packed {
    logic pixel_changed;
    logic area_changed;
    logic area_done;
  } pixel_rsp_t;

  typedef struct packed {
    logic [9:0] logical_width;
    logic [9:0] logical_height;
    logic       mirror_horizontal;
    logic       mirror_vertical;
    logic       swap_axes;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
  } map_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

endpackage

/* hdl/rmfbw_map.sv */
module rmfbw_map (
  input  logic [9:0]      pixel_x_i,
  input  logic [9:0]      pixel_y_i,
  input  rmfbw_pkg::cfg_t cfg_i,
  output rmfbw_pkg::map_t map_o
);

  localparam logic [15:0] ColLast = 16'(rmfbw_pkg::PANEL_COLS - 1);
  localparam logic [15:0] RowLast = 16'(rmfbw_pkg::PANEL_ROWS - 1);

  logic                        in_bounds;
  logic [15:0]                 col0, row0, col1, row1, col2, row2;
  logic                        on_panel;
  logic [rmfbw_pkg::IDX_W-1:0] idx;

  // Logical window check
  assign in_bounds = (pixel_x_i < cfg_i.logical_width) && (pixel_y_i < cfg_i.logical_height);

  // Rotate clockwise, mirror, swap (16-bit wrapping arithmetic)
  assign col0 = ColLast - {6'd0, pixel_y_i};
  assign row0 = {6'd0, pixel_x_i};
  assign col1 = cfg_i.mirror_horizontal ? (ColLast - col0) : col0;
  assign row1 = cfg_i.mirror_vertical   ? (RowLast - row0) : row0;
  assign col2 = cfg_i.swap_axes ? row1 : col1;
  assign row2 = cfg_i.swap_axes ? col1 : row1;

  assign on_panel = (col2 < 16'(rmfbw_pkg::PANEL_COLS)) && (row2 < 16'(rmfbw_pkg::PANEL_ROWS));

  // Byte index: row stride times row plus column byte
  assign idx = rmfbw_pkg::IDX_W'(row2[rmfbw_pkg::ROW_W-1:0])
             * rmfbw_pkg::IDX_W'(rmfbw_pkg::ROW_BYTES)
             + rmfbw_pkg::IDX_W'(col2[rmfbw_pkg::COL_W-1:3]);

  assign map_o.hit  = in_bounds && on_panel
                   && (idx < rmfbw_pkg::IDX_W'(rmfbw_pkg::STORE_BYTES));
  assign map_o.addr = rmfbw_pkg::ADDR_W'(idx);
  assign map_o.mask = rmfbw_pkg::MASK_MSB >> col2[2:0];

endmodule

/* hdl/rmfbw_store.sv */
module rmfbw_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [rmfbw_pkg::ADDR_W-1:0] rd_addr_i,
  output logic [7:0]                   rd_data_o,
  input  rmfbw_pkg::wr_req_t           wr_i,
  output logic                         clr_done_o
);

  logic [7:0]                  mem [rmfbw_pkg::STORE_BYTES];
  logic [rmfbw_pkg::CLR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [7:0]                  rd_data_q;

  assign clr_done_o = (clr_cnt_q == rmfbw_pkg::CLR_W'(rmfbw_pkg::STORE_BYTES));
  assign clr_cnt_d  = clr_done_o ? clr_cnt_q : clr_cnt_q + 1'b1;

  // Clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Single write port: clear sweep first, then pixel writes
  always_ff @(posedge clk_i) begin
    if (!clr_done_o) begin
      mem[clr_cnt_q[rmfbw_pkg::ADDR_W-1:0]] <= rmfbw_pkg::BYTE_WHITE;
    end else if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read, read-before-write on a collision
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/rotated_mono_framebuffer_writer_top.sv */
// Rotated 1bpp framebuffer writer. Takes one pixel request per cycle when
// the output is free and returns one response per request, in order, from
// the output register after stage 1. Each pixel is a read-modify-write of
// one byte of the on-chip store: the read is issued at acceptance and the
// write lands when stage 1 advances; a back-to-back request to the same byte
// picks up the fresh byte from a bypass register, so a new pixel can enter
// every cycle while the output is free. After reset the store is swept to
// white one byte per cycle over all 12480 bytes (PANEL_COLS * PANEL_ROWS / 8),
// and no pixel request is taken until the sweep ends; configuration writes
// are taken at any time and should only be issued while no pixel is in flight.
module rotated_mono_framebuffer_writer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  rmfbw_pkg::pixel_req_t           in_pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rmfbw_pkg::pixel_rsp_t           out_result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rmfbw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [9:0]                      cfg_data_i
);

  rmfbw_pkg::cfg_t    cfg_q, cfg_d;
  rmfbw_pkg::map_t    map;
  rmfbw_pkg::wr_req_t wr;

  logic                         clr_done;
  logic                         in_accept;
  logic [7:0]                   rd_data;
  logic                         s1_valid_q;
  logic                         s1_hit_q;
  logic [rmfbw_pkg::ADDR_W-1:0] s1_addr_q;
  logic [7:0]                   s1_mask_q;
  logic                         s1_white_q;
  logic                         s1_end_q;
  logic                         s1_adv;
  logic                         fwd_valid_q;
  logic [rmfbw_pkg::ADDR_W-1:0] fwd_addr_q;
  logic [7:0]                   fwd_data_q;
  logic [7:0]                   old_byte, new_byte;
  logic                         changed, area_changed;
  logic                         dirty_q, dirty_d;
  logic                         out_valid_q;
  rmfbw_pkg::pixel_rsp_t        out_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rmfbw_pkg::CFG_LOGICAL_WIDTH:  cfg_d.logical_width     = cfg_data_i;
        rmfbw_pkg::CFG_LOGICAL_HEIGHT: cfg_d.logical_height    = cfg_data_i;
        rmfbw_pkg::CFG_MIRROR_H:       cfg_d.mirror_horizontal = cfg_data_i[0];
        rmfbw_pkg::CFG_MIRROR_V:       cfg_d.mirror_vertical   = cfg_data_i[0];
        rmfbw_pkg::CFG_SWAP_AXES:      cfg_d.swap_axes         = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.logical_width     <= rmfbw_pkg::WIDTH_RESET;
      cfg_q.logical_height    <= rmfbw_pkg::HEIGHT_RESET;
      cfg_q.mirror_horizontal <= 1'b0;
      cfg_q.mirror_vertical   <= 1'b0;
      cfg_q.swap_axes         <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Coordinate mapping on the incoming request
  rmfbw_map u_map (
    .pixel_x_i (in_pixel_i.pixel_x),
    .pixel_y_i (in_pixel_i.pixel_y),
    .cfg_i     (cfg_q),
    .map_o     (map)
  );

  // Handshake: stage 1 moves on when the output register is free or drains
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = clr_done && (!s1_valid_q || s1_adv);
  assign in_accept  = in_valid_i && in_ready_o;

  rmfbw_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rd_addr_i  (map.addr),
    .rd_data_o  (rd_data),
    .wr_i       (wr),
    .clr_done_o (clr_done)
  );

  // Stage 1 request registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_hit_q   <= map.hit;
      s1_addr_q  <= map.addr;
      s1_mask_q  <= map.mask;
      s1_white_q <= (in_pixel_i.pixel_rgb565 >= rmfbw_pkg::WHITE_THRESHOLD);
      s1_end_q   <= in_pixel_i.area_end;
    end
  end

  // Modify: bypass the last written byte when it is the same entry
  assign old_byte = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rd_data;
  assign new_byte = s1_white_q ? (old_byte | s1_mask_q) : (old_byte & ~s1_mask_q);
  assign changed  = s1_hit_q && (new_byte != old_byte);

  assign wr.en   = s1_adv && s1_hit_q;
  assign wr.addr = s1_addr_q;
  assign wr.data = new_byte;

  // Bypass register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (wr.en) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr.en) begin
      fwd_addr_q <= wr.addr;
      fwd_data_q <= wr.data;
    end
  end

  // Area change tracking
  assign area_changed = dirty_q || changed;
  assign dirty_d      = s1_end_q ? 1'b0 : area_changed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q <= 1'b0;
    end else if (s1_adv) begin
      dirty_q <= dirty_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.pixel_changed <= changed;
      out_q.area_changed  <= area_changed;
      out_q.area_done     <= s1_end_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

  // Checks
  a_no_req_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_done |-> !in_ready_o)
    else $error("request taken during clear sweep");

  a_write_from_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (s1_valid_q && clr_done))
    else $error("store write without a live request");

  a_area_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_end_q) |=> !dirty_q)
    else $error("area flag not cleared at area end");

  a_change_implies_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.pixel_changed || out_q.area_changed))
    else $error("pixel change missing from area flag");

  a_bypass_tracks_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |=> (fwd_valid_q && (fwd_addr_q == $past(wr.addr))))
    else $error("bypass register lost the last write");

endmodule

/* dv/rotated_mono_framebuffer_writer_top_tb.sv */
`timescale 1ns / 100ps

module rotated_mono_framebuffer_writer_top_tb;
  import rmfbw_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned HOLD_AT_COUNT = 1100;

  // Shadow of the panel store: predicts the change flags of every pixel request
  class fb_shadow;
    logic [7:0]  store_copy [STORE_BYTES];
    logic [9:0]  width_q;
    logic [9:0]  height_q;
    logic        mirror_h_q;
    logic        mirror_v_q;
    logic        swap_q;
    logic        area_dirty_q;
    pixel_rsp_t  pending_flags [$];
    int          mismatches;

    function new();
      foreach (store_copy[i]) store_copy[i] = BYTE_WHITE;
      width_q      = WIDTH_RESET;
      height_q     = HEIGHT_RESET;
      mirror_h_q   = 1'b0;
      mirror_v_q   = 1'b0;
      swap_q       = 1'b0;
      area_dirty_q = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [9:0] data);
      case (idx)
        CFG_LOGICAL_WIDTH:  width_q    = data;
        CFG_LOGICAL_HEIGHT: height_q   = data;
        CFG_MIRROR_H:       mirror_h_q = data[0];
        CFG_MIRROR_V:       mirror_v_q = data[0];
        CFG_SWAP_AXES:      swap_q     = data[0];
        default: ;
      endcase
    endfunction

    // Rotate, mirror, swap, then read-modify-write the shadow byte
    function void note_pixel(pixel_req_t p);
      logic [15:0] col;
      logic [15:0] row;
      logic [15:0] tmp;
      int unsigned idx;
      logic [7:0]  bit_mask;
      logic [7:0]  old_byte;
      logic [7:0]  new_byte;
      bit          hit;
      bit          changed;
      pixel_rsp_t  flags;
      changed = 1'b0;
      hit = (p.pixel_x < width_q) && (p.pixel_y < height_q);
      col = 16'(PANEL_COLS - 1) - {6'd0, p.pixel_y};
      row = {6'd0, p.pixel_x};
      if (mirror_h_q) col = 16'(PANEL_COLS - 1) - col;
      if (mirror_v_q) row = 16'(PANEL_ROWS - 1) - row;
      if (swap_q) begin
        tmp = col;
        col = row;
        row = tmp;
      end
      if (col >= PANEL_COLS || row >= PANEL_ROWS) hit = 1'b0;
      idx = row * ROW_BYTES + (col >> 3);
      if (idx >= STORE_BYTES) hit = 1'b0;
      if (hit) begin
        bit_mask = MASK_MSB >> col[2:0];
        old_byte = store_copy[idx];
        new_byte = (p.pixel_rgb565 >= WHITE_THRESHOLD) ? (old_byte | bit_mask)
                                                       : (old_byte & ~bit_mask);
        store_copy[idx] = new_byte;
        changed = (old_byte != new_byte);
      end
      area_dirty_q = area_dirty_q | changed;
      flags.pixel_changed = changed;
      flags.area_changed  = area_dirty_q;
      flags.area_done     = p.area_end;
      pending_flags.push_back(flags);
      if (p.area_end) area_dirty_q = 1'b0;
    endfunction

    task report_mismatch(string what, logic got, logic want);
      $display("%0t: MISMATCH %s got %0b want %0b", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(pixel_rsp_t r);
      pixel_rsp_t want;
      if (pending_flags.size() == 0) begin
        report_mismatch("response with no request pending", 1'b1, 1'b0);
      end else begin
        want = pending_flags.pop_front();
        if (r.pixel_changed !== want.pixel_changed)
          report_mismatch("pixel_changed", r.pixel_changed, want.pixel_changed);
        if (r.area_changed !== want.area_changed)
          report_mismatch("area_changed", r.area_changed, want.area_changed);
        if (r.area_done !== want.area_done)
          report_mismatch("area_done", r.area_done, want.area_done);
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  pixel_req_t           in_pixel_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  pixel_rsp_t           out_result_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [9:0]           cfg_data_i;

  fb_shadow    sb;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_done;
  int unsigned cur_w;
  int unsigned cur_h;

  rotated_mono_framebuffer_writer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_pixel_i   (in_pixel_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_result_o (out_result_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic pixel_req_t mk_pixel(int unsigned x, int unsigned y,
                                          logic [15:0] rgb, logic last);
    pixel_req_t p;
    p.pixel_x      = 10'(x);
    p.pixel_y      = 10'(y);
    p.pixel_rgb565 = rgb;
    p.area_end     = last;
    return p;
  endfunction

  // Offer one pixel request; idle pattern follows the progress of the run
  task send_pixel(input pixel_req_t p);
    if (items_sent < 450) begin
      send_idle_pct = 32;
      recv_idle_pct = 47;
    end else if (items_sent < 900) begin
      send_idle_pct = 47;
      recv_idle_pct = 32;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pixel_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(p);
    items_sent++;
  endtask

  // Let every response drain before touching the registers
  task wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_flags.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [9:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  task set_geometry(input int unsigned w, input int unsigned h,
                    input logic mh, input logic mv, input logic sw);
    wait_idle();
    write_reg(CFG_LOGICAL_WIDTH, 10'(w));
    write_reg(CFG_LOGICAL_HEIGHT, 10'(h));
    write_reg(CFG_MIRROR_H, {9'd0, mh});
    write_reg(CFG_MIRROR_V, {9'd0, mv});
    write_reg(CFG_SWAP_AXES, {9'd0, sw});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  // Mostly small rectangular areas swept in either order, plus loose noise
  task run_areas(input int unsigned count);
    int unsigned goal;
    int unsigned aw;
    int unsigned ah;
    int unsigned x0;
    int unsigned y0;
    int unsigned n;
    int unsigned k;
    int unsigned kind;
    int unsigned shade;
    bit          col_major;
    bit          broken;
    pixel_req_t  p;
    goal = items_sent + count;
    while (items_sent < goal) begin
      kind = $urandom_range(0, 9);
      if (kind >= 8) begin
        p.pixel_x      = 10'($urandom);
        p.pixel_y      = 10'($urandom);
        p.pixel_rgb565 = 16'($urandom);
        p.area_end     = 1'($urandom);
        send_pixel(p);
      end else begin
        aw        = $urandom_range(1, 8);
        ah        = $urandom_range(1, 6);
        x0        = $urandom_range(0, cur_w);
        y0        = $urandom_range(0, cur_h);
        col_major = 1'($urandom);
        broken    = (kind == 7);
        shade     = $urandom_range(0, 3);
        n         = aw * ah;
        for (k = 0; k < n; k++) begin
          p.pixel_x = 10'(x0 + (col_major ? k / ah : k % aw));
          p.pixel_y = 10'(y0 + (col_major ? k % ah : k / aw));
          case (shade)
            0:       p.pixel_rgb565 = 16'($urandom_range(0, 16'h7ffe));
            1:       p.pixel_rgb565 = 16'($urandom_range(16'h7fff, 16'hffff));
            2:       p.pixel_rgb565 = 16'($urandom);
            default: p.pixel_rgb565 = 16'h7ffe + 16'($urandom_range(0, 1));
          endcase
          // a broken area drops its end marker at random points
          p.area_end = broken ? ($urandom_range(0, 7) == 0) : (k == n - 1);
          send_pixel(p);
        end
      end
    end
  endtask

  // Response side: random back-pressure and one long hold-off
  initial begin
    out_ready_i  = 1'b0;
    results_seen = 0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= HOLD_AT_COUNT) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_result_o);
        results_seen++;
      end
    end
  end

  // Main sequence
  initial begin
    sb            = new();
    items_sent    = 0;
    send_idle_pct = 32;
    recv_idle_pct = 47;
    cur_w         = WIDTH_RESET;
    cur_h         = HEIGHT_RESET;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_pixel_i    = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_LOGICAL_WIDTH;
    cfg_data_i    = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: threshold edges, corners, dropped pixels, same-byte runs
    set_geometry(416, 240, 1'b0, 1'b0, 1'b0);
    send_pixel(mk_pixel(0, 0, 16'h0000, 1'b0));
    send_pixel(mk_pixel(0, 0, 16'h0000, 1'b0));
    send_pixel(mk_pixel(0, 0, 16'h7ffe, 1'b0));
    send_pixel(mk_pixel(0, 0, 16'h7fff, 1'b0));
    send_pixel(mk_pixel(0, 0, 16'hffff, 1'b1));
    send_pixel(mk_pixel(415, 239, 16'h0000, 1'b0));
    send_pixel(mk_pixel(415, 239, 16'h8000, 1'b1));
    send_pixel(mk_pixel(416, 0, 16'h0000, 1'b0));
    send_pixel(mk_pixel(0, 240, 16'h0000, 1'b1));
    send_pixel(mk_pixel(1023, 1023, 16'hffff, 1'b0));
    send_pixel(mk_pixel(512, 0, 16'h0000, 1'b0));
    send_pixel(mk_pixel(0, 512, 16'h0000, 1'b1));
    send_pixel(mk_pixel(1, 0, 16'h0000, 1'b0));
    send_pixel(mk_pixel(1, 1, 16'h0000, 1'b0));
    send_pixel(mk_pixel(1, 2, 16'h0000, 1'b0));
    send_pixel(mk_pixel(1, 7, 16'h0000, 1'b0));
    send_pixel(mk_pixel(1, 8, 16'h0000, 1'b1));
    send_pixel(mk_pixel(2, 3, 16'h5555, 1'b0));
    send_pixel(mk_pixel(2, 3, 16'haaaa, 1'b1));
    send_pixel(mk_pixel(2, 3, 16'haaaa, 1'b1));

    // Random phases over several geometries, extremes included
    set_geometry(1023, 1023, 1'b1, 1'b0, 1'b0);
    run_areas(300);
    set_geometry(1023, 1023, 1'b0, 1'b1, 1'b1);
    run_areas(300);
    set_geometry(0, 0, 1'b1, 1'b1, 1'b1);
    run_areas(50);
    set_geometry(240, 416, 1'b1, 1'b1, 1'b1);
    run_areas(350);
    set_geometry($urandom_range(1, 1023), $urandom_range(1, 1023),
                 1'($urandom), 1'($urandom), 1'($urandom));
    run_areas(350);

    // Drain and settle
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_flags.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
